// ===== sv/oets_pkg.sv =====
// package: widths, request/response types and cell control for the transposition sorter
package oets_pkg;

   localparam int SORT_DEPTH = 32;
   localparam int VALUE_W    = 32;
   localparam int IDX_W      = $clog2(SORT_DEPTH);
   localparam int CNT_W      = $clog2(SORT_DEPTH + 1);

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      final_res;
      logic                      overflow;
   } rsp_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_LOAD   = 2'd1,
      CELL_SWAP   = 2'd2,
      CELL_UNLOAD = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic             parity;
      logic [CNT_W-1:0] count;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SORT = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ===== sv/oets_cell.sv =====
// one sorter cell: holds one element, shifts in either direction or compare-exchanges
module oets_cell (
   input  logic                           clock,
   input  oets_pkg::cell_ctl_type         ctl,
   input  logic [oets_pkg::IDX_W-1:0]     cell_idx,
   input  logic signed [oets_pkg::VALUE_W-1:0] left_val,
   input  logic signed [oets_pkg::VALUE_W-1:0] right_val,
   output logic signed [oets_pkg::VALUE_W-1:0] val_out
);
   import oets_pkg::*;

   logic signed [VALUE_W-1:0] val_ff;
   logic signed [VALUE_W-1:0] val_in;
   logic [CNT_W-1:0]          idx_ext;
   logic                      act_right;
   logic                      act_left;

   assign idx_ext   = CNT_W'(cell_idx);
   assign act_right = (cell_idx[0] == ctl.parity) && ((idx_ext + CNT_W'(1)) < ctl.count);
   assign act_left  = (cell_idx[0] != ctl.parity) && (idx_ext != '0) && (idx_ext < ctl.count);

   always_comb begin
      val_in = val_ff;
      unique case (ctl.op)
         CELL_HOLD: begin
            val_in = val_ff;
         end
         CELL_LOAD: begin
            val_in = left_val;
         end
         CELL_SWAP: begin
            if (act_right && (val_ff > right_val)) begin
               val_in = right_val;
            end else if (act_left && (left_val > val_ff)) begin
               val_in = left_val;
            end
         end
         CELL_UNLOAD: begin
            val_in = right_val;
         end
         default: begin
            val_in = val_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

   assign val_out = val_ff;

endmodule

// ===== sv/odd_even_transposition_sorter.sv =====
// top level: load control, sort phases and result unload over a chain of cells
// after the last request is accepted the sorter runs its exchange phases, then emits one result
// per cycle, one for each of the n stored elements (n = stored elements, at most SORT_DEPTH)
// sorting runs one exchange phase per cycle; no new batch is accepted until the last result is out
// busy is high while sorting and unloading; the receiver cannot stall results
// reset: synchronous, clears fill count, drop flag, state and the result strobe
module odd_even_transposition_sorter (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  oets_pkg::req_type req_data,
   output logic              rsp_strobe,
   output oets_pkg::rsp_type rsp_data
);
   import oets_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] step_ff, step_in;
   logic             dropped_ff, dropped_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;
   cell_ctl_type     ctl;
   logic             accept;
   logic             room;
   logic             step_end;

   logic signed [VALUE_W-1:0] cell_val [SORT_DEPTH];

   assign busy     = (state_ff != ST_LOAD);
   assign accept   = start && !busy;
   assign room     = (fill_ff < CNT_W'(SORT_DEPTH));
   assign step_end = (step_ff == (fill_ff - CNT_W'(1)));

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      step_in    = step_ff;
      dropped_in = dropped_ff;
      strobe_in  = 1'b0;
      rsp_in     = rsp_ff;
      ctl.op     = CELL_HOLD;
      ctl.parity = step_ff[0];
      ctl.count  = fill_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  ctl.op  = CELL_LOAD;
                  fill_in = fill_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_data.last) begin
                  state_in = ST_SORT;
                  step_in  = '0;
               end
            end
         end
         ST_SORT: begin
            ctl.op  = CELL_SWAP;
            step_in = step_ff + CNT_W'(1);
            if (step_end) begin
               state_in = ST_EMIT;
               step_in  = '0;
            end
         end
         ST_EMIT: begin
            ctl.op              = CELL_UNLOAD;
            strobe_in           = 1'b1;
            rsp_in.sorted_value = cell_val[0];
            rsp_in.final_res    = step_end;
            rsp_in.overflow     = dropped_ff;
            step_in             = step_ff + CNT_W'(1);
            if (step_end) begin
               state_in   = ST_LOAD;
               fill_in    = '0;
               dropped_in = 1'b0;
               step_in    = '0;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         fill_ff    <= '0;
         step_ff    <= '0;
         dropped_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         step_ff    <= step_in;
         dropped_ff <= dropped_in;
         strobe_ff  <= strobe_in;
      end
      rsp_ff <= rsp_in;
   end

   for (genvar g = 0; g < SORT_DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_v;
      logic signed [VALUE_W-1:0] right_v;
      if (g == 0) begin : g_first
         assign left_v = req_data.value;
      end else begin : g_mid_l
         assign left_v = cell_val[g-1];
      end
      if (g == SORT_DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_val[g+1];
      end
      oets_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .cell_idx  (IDX_W'(g)),
         .left_val  (left_v),
         .right_val (right_v),
         .val_out   (cell_val[g])
      );
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef SYNTH
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("state not one-hot");

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      strobe_ff |-> $past(state_ff == ST_EMIT))
      else $error("result strobe outside unload");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(SORT_DEPTH))
      else $error("fill count beyond depth");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      dropped_ff |-> (fill_ff == CNT_W'(SORT_DEPTH)))
      else $error("drop flag set with room left");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (fill_ff != '0))
      else $error("sort or unload with empty store");
`endif

endmodule
